### design/dvft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvft_pkg
// shared types and constants for the distinct value frequency table
// ----------------------------------------------------------------------------
package dvft_pkg;

    localparam int VALUE_W = 32;
    localparam int OCC_W   = 16;

    typedef struct packed {
        logic               vld;
        logic [VALUE_W-1:0] value;
    } tok_t;

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_DRAIN,
        ST_EMIT
    } state_t;

endpackage

### design/dvft_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvft_cell
// one table entry: matches or claims a passing value, shifts out on emission
// ----------------------------------------------------------------------------
module dvft_cell
    import dvft_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   shift,
    input  tok_t                   tok_in,
    output tok_t                   tok_out,
    input  logic                   nb_occ,
    input  logic [VALUE_W-1:0]     nb_value,
    input  logic [COUNT_WIDTH-1:0] nb_count,
    output logic                   occ,
    output logic [VALUE_W-1:0]     value,
    output logic [COUNT_WIDTH-1:0] count
);

    logic                   occ_reg;
    logic                   occ_next;
    logic [VALUE_W-1:0]     value_reg;
    logic [VALUE_W-1:0]     value_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic                   tok_vld_reg;
    logic                   tok_vld_next;
    logic [VALUE_W-1:0]     tok_value_reg;

    always_comb
    begin
        occ_next     = occ_reg;
        value_next   = value_reg;
        count_next   = count_reg;
        tok_vld_next = 1'b0;
        if (shift)
        begin
            occ_next   = nb_occ;
            value_next = nb_value;
            count_next = nb_count;
        end
        else if (tok_in.vld)
        begin
            if (occ_reg && (value_reg == tok_in.value))
            begin
                // saturating hit
                if (count_reg != {COUNT_WIDTH{1'b1}})
                begin
                    count_next = count_reg + COUNT_WIDTH'(1);
                end
            end
            else if (!occ_reg)
            begin
                occ_next   = 1'b1;
                value_next = tok_in.value;
                count_next = COUNT_WIDTH'(1);
            end
            else
            begin
                tok_vld_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg     <= 1'b0;
            tok_vld_reg <= 1'b0;
        end
        else
        begin
            occ_reg     <= occ_next;
            tok_vld_reg <= tok_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg     <= value_next;
        count_reg     <= count_next;
        tok_value_reg <= tok_in.value;
    end

    assign tok_out.vld   = tok_vld_reg;
    assign tok_out.value = tok_value_reg;
    assign occ           = occ_reg;
    assign value         = value_reg;
    assign count         = count_reg;

endmodule

### design/distinct_value_frequency_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distinct_value_frequency_table_core
// counts distinct values in a row of cells and emits value/count pairs
// ----------------------------------------------------------------------------
// throughput: one value per cycle while a set is collected
// after the tlast transaction: the cell row drains, then one pair per cycle
//   is loaded while m_axis_tready does not hold the output stage
// no input is taken from the tlast transaction until the last pair is loaded
// reset clears occupancy, in-flight values, overflow and the output stage
module distinct_value_frequency_table_core
    import dvft_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64,
    parameter int COUNT_WIDTH   = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // value[31:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // distinct_value[31:0], occurrences[47:32]
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // overflowed
);

    state_t state_reg;
    state_t state_next;

    tok_t                   tok [TABLE_ENTRIES+1];
    logic                   occ [TABLE_ENTRIES+1];
    logic [VALUE_W-1:0]     val [TABLE_ENTRIES+1];
    logic [COUNT_WIDTH-1:0] cnt [TABLE_ENTRIES+1];

    logic [TABLE_ENTRIES-1:0] tok_vld_vec;
    logic [TABLE_ENTRIES-1:0] occ_vec;
    logic                     any_tok;
    logic                     in_acc;
    logic                     load;
    logic                     load_last;
    logic [OCC_W-1:0]         occ16;

    logic               ovf_reg;
    logic               ovf_next;
    logic               m_valid_reg;
    logic               m_valid_next;
    logic [VALUE_W-1:0] m_value_reg;
    logic [OCC_W-1:0]   m_count_reg;
    logic               m_last_reg;
    logic               m_ovf_reg;

    assign in_acc = s_axis_tvalid && s_axis_tready;

    assign tok[0].vld   = in_acc;
    assign tok[0].value = s_axis_tdata;

    assign occ[TABLE_ENTRIES] = 1'b0;
    assign val[TABLE_ENTRIES] = '0;
    assign cnt[TABLE_ENTRIES] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++)
        begin : g_cell
            dvft_cell #(
                .COUNT_WIDTH (COUNT_WIDTH)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift    (load),
                .tok_in   (tok[gi]),
                .tok_out  (tok[gi+1]),
                .nb_occ   (occ[gi+1]),
                .nb_value (val[gi+1]),
                .nb_count (cnt[gi+1]),
                .occ      (occ[gi]),
                .value    (val[gi]),
                .count    (cnt[gi])
            );
            assign tok_vld_vec[gi] = tok[gi+1].vld;
            assign occ_vec[gi]     = occ[gi];
        end
    endgenerate

    assign any_tok = |tok_vld_vec;

    // clamp or zero-extend the head count to the 16-bit field
    generate
        if (COUNT_WIDTH > OCC_W)
        begin : g_clamp
            assign occ16 = (|cnt[0][COUNT_WIDTH-1:OCC_W]) ? {OCC_W{1'b1}}
                                                          : cnt[0][OCC_W-1:0];
        end
        else
        begin : g_ext
            assign occ16 = OCC_W'(cnt[0]);
        end
    endgenerate

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_COLLECT:
            begin
                if (in_acc && s_axis_tlast)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!any_tok)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (load_last)
                begin
                    state_next = ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        s_axis_tready = 1'b0;
        load          = 1'b0;
        unique case (state_reg)
            ST_COLLECT:
            begin
                s_axis_tready = 1'b1;
            end
            ST_DRAIN:
            begin
                load = 1'b0;
            end
            ST_EMIT:
            begin
                load = occ[0] && (!m_valid_reg || m_axis_tready);
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
    end

    assign load_last = load && !occ[1];

    always_comb
    begin
        ovf_next = ovf_reg;
        if (tok[TABLE_ENTRIES].vld)
        begin
            ovf_next = 1'b1;
        end
        else if (load_last)
        begin
            ovf_next = 1'b0;
        end
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_COLLECT;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            m_value_reg <= val[0];
            m_count_reg <= occ16;
            m_last_reg  <= !occ[1];
            m_ovf_reg   <= ovf_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_count_reg, m_value_reg};
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = m_ovf_reg;

    // table fills from the head with no gaps
    a_occ_prefix : assert property (@(posedge clk) disable iff (!rst_n)
        (occ_vec & (occ_vec + TABLE_ENTRIES'(1))) == '0)
        else $error("table occupancy has a gap");

    // no value is still travelling the row while pairs are shifted out
    a_emit_no_tok : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> !any_tok)
        else $error("value in flight during emission");

    // loading the final pair returns to collection with an empty table
    a_last_returns : assert property (@(posedge clk) disable iff (!rst_n)
        load_last |=> (state_reg == ST_COLLECT) && !occ[0] && !ovf_reg)
        else $error("table not cleared after final pair");

    // emission always starts with at least one stored entry
    a_emit_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) && !any_tok |-> occ[0])
        else $error("empty table at emission");

endmodule
